>>> hw/rtl/nat_pkg.sv
// shared types and codes for the nat wildcard translation table
package nat_pkg;

  localparam int unsigned IpW   = 32;
  localparam int unsigned PortW = 16;
  localparam int unsigned KeyW  = 50;
  localparam int unsigned XlatW = 48;

  localparam logic [2:0] StAdded = 3'd0;
  localparam logic [2:0] StDup   = 3'd1;
  localparam logic [2:0] StFull  = 3'd2;
  localparam logic [2:0] StXlat  = 3'd3;
  localparam logic [2:0] StNone  = 3'd4;

  localparam logic [1:0] MrExact   = 2'd0;
  localparam logic [1:0] MrAnyIp   = 2'd1;
  localparam logic [1:0] MrAnyPort = 2'd2;
  localparam logic [1:0] MrNone    = 2'd3;

  localparam logic ModeAdd = 1'b0;

  // classified word passed from front to back
  typedef struct packed {
    logic               is_add;
    logic [KeyW-1:0]    key;    // add key or exact translate key
    logic [KeyW-1:0]    key_ai; // any address, same port
    logic [KeyW-1:0]    key_ap; // same address, any port
    logic [XlatW-1:0]   xlat;
  } nat_cmd_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [1:0]       matched_rule;
    logic [IpW-1:0]   out_ip;
    logic [PortW-1:0] out_port;
  } nat_res_t;

  function automatic logic [KeyW-1:0] make_key(logic [IpW-1:0] ip, logic [PortW-1:0] port,
                                               logic ipw, logic ptw);
    make_key = {ipw, ptw, (ipw ? {IpW{1'b0}} : ip), (ptw ? {PortW{1'b0}} : port)};
  endfunction

endpackage

>>> hw/rtl/nat_front.sv
// front end: accepts words, builds keys, feeds a two-entry queue
module nat_front import nat_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [98:0]   in_data_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output nat_cmd_t      cmd_o
);
  nat_cmd_t       q_mem [2];
  logic           wp_q, wp_d, rp_q, rp_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           push, pop;
  nat_cmd_t       c;
  logic [IpW-1:0] ip;
  logic [PortW-1:0] port;

  assign ip   = in_data_i[32:1];
  assign port = in_data_i[48:33];

  always_comb begin
    c.is_add = (in_data_i[0] == ModeAdd);
    c.key    = c.is_add ? make_key(ip, port, in_data_i[49], in_data_i[50])
                        : make_key(ip, port, 1'b0, 1'b0);
    c.key_ai = make_key(ip, port, 1'b1, 1'b0);
    c.key_ap = make_key(ip, port, 1'b0, 1'b1);
    c.xlat   = {in_data_i[82:51], in_data_i[98:83]};
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = cmd_valid_o && cmd_ready_i;
  assign wp_d = push ? ~wp_q : wp_q;
  assign rp_d = pop ? ~rp_q : rp_q;
  assign cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wp_q] <= c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      wp_q <= wp_d; rp_q <= rp_d; cnt_q <= cnt_d;
    end
  end
endmodule

>>> hw/rtl/nat_back.sv
// back end: rule store with parallel match, one word at a time
module nat_back import nat_pkg::*; #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cmd_valid_i,
  output logic     cmd_ready_o,
  input  nat_cmd_t cmd_i,
  output logic     res_valid_o,
  input  logic     res_ready_i,
  output nat_res_t res_o
);
  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  logic [ENTRIES-1:0] valid_q;
  logic [KeyW-1:0]    key_q  [ENTRIES];
  logic [XlatW-1:0]   xlat_q [ENTRIES];
  logic [CntW-1:0]    count_q;
  logic               rv_q;
  nat_res_t           res_q, res_d;
  logic               take, hit0, hit1, hit2, full, wr;
  logic [XlatW-1:0]   x0, x1, x2;

  assign cmd_ready_o = !rv_q || res_ready_i;
  assign take = cmd_valid_i && cmd_ready_o;
  assign full = (count_q >= CntW'(ENTRIES));

  // hits are ORed across all entries per key; entries are unique so any hit is the one
  always_comb begin
    hit0 = 1'b0; hit1 = 1'b0; hit2 = 1'b0;
    x0 = '0; x1 = '0; x2 = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (valid_q[i] && key_q[i] == cmd_i.key)    begin hit0 = 1'b1; x0 = x0 | xlat_q[i]; end
      if (valid_q[i] && key_q[i] == cmd_i.key_ai) begin hit1 = 1'b1; x1 = x1 | xlat_q[i]; end
      if (valid_q[i] && key_q[i] == cmd_i.key_ap) begin hit2 = 1'b1; x2 = x2 | xlat_q[i]; end
    end
  end

  always_comb begin
    res_d = '{status: StNone, matched_rule: MrNone, out_ip: '0, out_port: '0};
    wr = 1'b0;
    if (cmd_i.is_add) begin
      if (hit0)      res_d.status = StDup;
      else if (full) res_d.status = StFull;
      else begin
        res_d.status = StAdded;
        wr = 1'b1;
      end
    end else if (hit0) begin
      res_d = '{status: StXlat, matched_rule: MrExact, out_ip: x0[47:16], out_port: x0[15:0]};
    end else if (hit1) begin
      res_d = '{status: StXlat, matched_rule: MrAnyIp, out_ip: x1[47:16], out_port: x1[15:0]};
    end else if (hit2) begin
      res_d = '{status: StXlat, matched_rule: MrAnyPort, out_ip: x2[47:16],
                out_port: x2[15:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && wr) begin
      key_q[count_q[IdxW-1:0]]  <= cmd_i.key;
      xlat_q[count_q[IdxW-1:0]] <= cmd_i.xlat;
    end
    if (take) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0; count_q <= '0; rv_q <= 1'b0;
    end else begin
      if (take) rv_q <= 1'b1;
      else if (res_ready_i) rv_q <= 1'b0;
      if (take && wr) begin
        valid_q[count_q[IdxW-1:0]] <= 1'b1;
        count_q <= count_q + 1'b1;
      end
    end
  end

  assign res_valid_o = rv_q;
  assign res_o       = res_q;
endmodule

>>> hw/rtl/nat_wildcard_translation_table_unit.sv
// nat wildcard translation table: front classifier, queue and rule store back end
// the accepted input word is registered in the queue, and its result in the output register
// throughput: one word per cycle while the output is not stalled; the back end compares all entries in parallel
// the two-entry queue between front and back lets either side stall alone
// reset clears all rule valid bits, the rule count, the queue pointers and count and the output valid flag
module nat_wildcard_translation_table_unit import nat_pkg::*; #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // ip, port, ip_is_wild, port_is_wild, new_ip, new_port, zero pad
  input  logic [103:0] s_axis_tdata,
  // mode
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status, matched_rule, out_ip, out_port, zero pad
  output logic [55:0] m_axis_tdata
);
  logic     cmd_valid, cmd_ready;
  nat_cmd_t cmd;
  nat_res_t res;

  nat_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_data_i({s_axis_tdata[97:0], s_axis_tuser}),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  nat_back #(.ENTRIES(ENTRIES)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {3'b000, res.out_port, res.out_ip, res.matched_rule, res.status};
endmodule
